/* src/lcd_pkg.sv */
`timescale 1ns / 1ps

package lcd_pkg;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  localparam int WORD_LEN   = 8;
  localparam int PREFIX_LEN = 9;
  localparam int MAC_POS_W  = 5;

  localparam logic [63:0] WORD_NFC  = {"NFC_", "READ"};
  localparam logic [63:0] WORD_SCAN = {"BLE_", "SCAN"};
  localparam logic [63:0] WORD_STOP = {"BLE_", "STOP"};
  localparam logic [71:0] WORD_RSSI = {"BLE_", "RSSI:"};

  typedef enum logic [1:0] {
    CMD_NFC  = 2'd0,
    CMD_SCAN = 2'd1,
    CMD_RSSI = 2'd2,
    CMD_STOP = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_NFC      = 2'd1,
    MODE_BLE_REG  = 2'd2,
    MODE_BLE_TRK  = 2'd3
  } mode_e;

  typedef enum logic {
    KIND_CMD = 1'b0,
    KIND_MAC = 1'b1
  } kind_e;

  typedef enum logic {
    EV_RX_NOTIFY = 1'b0,
    EV_STOP      = 1'b1
  } event_e;

  // command handed from the line tracker to the result sequencer
  typedef struct packed {
    logic valid;
    cmd_e code;
    logic has_mac;
    logic load_mac;
  } cmd_t;

  function automatic logic [7:0] word8_char(logic [63:0] word, logic [2:0] idx);
    return word[8 * (7 - int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] rssi_char(logic [3:0] idx);
    return WORD_RSSI[8 * (8 - int'(idx)) +: 8];
  endfunction

  function automatic mode_e mode_of(cmd_e code);
    mode_e m;
    unique case (code)
      CMD_NFC:  m = MODE_NFC;
      CMD_SCAN: m = MODE_BLE_REG;
      CMD_RSSI: m = MODE_BLE_TRK;
      CMD_STOP: m = MODE_IDLE;
      default:  m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

/* src/lcd_line_tracker.sv */
`timescale 1ns / 1ps

module lcd_line_tracker #(
  parameter int LINE_MAX = 62,
  parameter int MAC_LEN  = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          cmd_ready_i,
  output lcd_pkg::cmd_t cmd_o,
  output logic [7:0]    cmd_mac_o [MAC_LEN]
);

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int MW = (MAC_LEN > 1) ? $clog2(MAC_LEN) : 1;

  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] eff_q, eff_d;
  logic          zero_seen_q, zero_seen_d;
  logic          nfc_ok_q, nfc_ok_d;
  logic          scan_ok_q, scan_ok_d;
  logic          stop_ok_q, stop_ok_d;
  logic          rssi_ok_q, rssi_ok_d;
  logic [7:0]    cand_q [MAC_LEN];

  logic          is_eol;
  logic          accept;
  logic          store_byte;
  logic          grow_eff;
  logic          cand_we;
  logic [MW-1:0] cand_idx;
  logic          is_eight;
  logic          hit_nfc, hit_scan, hit_stop, hit_rssi;

  assign is_eol     = (rx_byte_i == lcd_pkg::CHAR_LF) || (rx_byte_i == lcd_pkg::CHAR_CR);
  // only a line end can produce a command, so only a line end waits on the sequencer
  assign in_stall_o = is_eol && !cmd_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign store_byte = accept && !is_eol && (len_q < LW'(LINE_MAX));
  assign grow_eff   = store_byte && !zero_seen_q && (rx_byte_i != 8'd0);

  assign cand_we  = grow_eff && (int'(eff_q) >= lcd_pkg::PREFIX_LEN) &&
                    (int'(eff_q) < lcd_pkg::PREFIX_LEN + MAC_LEN);
  assign cand_idx = MW'(eff_q - LW'(lcd_pkg::PREFIX_LEN));

  assign is_eight = (eff_q == LW'(lcd_pkg::WORD_LEN));
  assign hit_nfc  = is_eight && nfc_ok_q;
  assign hit_scan = is_eight && scan_ok_q;
  assign hit_stop = is_eight && stop_ok_q;
  assign hit_rssi = (int'(eff_q) >= lcd_pkg::PREFIX_LEN) && rssi_ok_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.code    = lcd_pkg::CMD_NFC;
    priority if (hit_nfc) begin
      cmd_o.code = lcd_pkg::CMD_NFC;
    end else if (hit_scan) begin
      cmd_o.code    = lcd_pkg::CMD_SCAN;
      cmd_o.has_mac = 1'b1;
    end else if (hit_rssi) begin
      cmd_o.code     = lcd_pkg::CMD_RSSI;
      cmd_o.has_mac  = 1'b1;
      cmd_o.load_mac = 1'b1;
    end else if (hit_stop) begin
      cmd_o.code = lcd_pkg::CMD_STOP;
    end
    cmd_o.valid = accept && is_eol && (len_q != '0) &&
                  (hit_nfc || hit_scan || hit_rssi || hit_stop);
  end

  // mac characters past the end of the effective line read as zero
  always_comb begin
    for (int i = 0; i < MAC_LEN; i++) begin
      cmd_mac_o[i] = ((lcd_pkg::PREFIX_LEN + i) < int'(eff_q)) ? cand_q[i] : 8'd0;
    end
  end

  always_comb begin
    len_d       = len_q;
    eff_d       = eff_q;
    zero_seen_d = zero_seen_q;
    nfc_ok_d    = nfc_ok_q;
    scan_ok_d   = scan_ok_q;
    stop_ok_d   = stop_ok_q;
    rssi_ok_d   = rssi_ok_q;
    if (accept && is_eol) begin
      len_d       = '0;
      eff_d       = '0;
      zero_seen_d = 1'b0;
      nfc_ok_d    = 1'b1;
      scan_ok_d   = 1'b1;
      stop_ok_d   = 1'b1;
      rssi_ok_d   = 1'b1;
    end else if (store_byte) begin
      len_d = len_q + LW'(1);
      if (!zero_seen_q && rx_byte_i == 8'd0) begin
        zero_seen_d = 1'b1;
      end
      if (grow_eff) begin
        eff_d = eff_q + LW'(1);
        if (int'(eff_q) < lcd_pkg::WORD_LEN) begin
          nfc_ok_d  = nfc_ok_q &&
                      (rx_byte_i == lcd_pkg::word8_char(lcd_pkg::WORD_NFC, eff_q[2:0]));
          scan_ok_d = scan_ok_q &&
                      (rx_byte_i == lcd_pkg::word8_char(lcd_pkg::WORD_SCAN, eff_q[2:0]));
          stop_ok_d = stop_ok_q &&
                      (rx_byte_i == lcd_pkg::word8_char(lcd_pkg::WORD_STOP, eff_q[2:0]));
        end
        if (int'(eff_q) < lcd_pkg::PREFIX_LEN) begin
          rssi_ok_d = rssi_ok_q && (rx_byte_i == lcd_pkg::rssi_char(eff_q[3:0]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      eff_q       <= '0;
      zero_seen_q <= 1'b0;
      nfc_ok_q    <= 1'b1;
      scan_ok_q   <= 1'b1;
      stop_ok_q   <= 1'b1;
      rssi_ok_q   <= 1'b1;
    end else begin
      len_q       <= len_d;
      eff_q       <= eff_d;
      zero_seen_q <= zero_seen_d;
      nfc_ok_q    <= nfc_ok_d;
      scan_ok_q   <= scan_ok_d;
      stop_ok_q   <= stop_ok_d;
      rssi_ok_q   <= rssi_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_we) begin
      cand_q[cand_idx] <= rx_byte_i;
    end
  end

endmodule

/* src/lcd_result_seq.sv */
`timescale 1ns / 1ps

module lcd_result_seq #(
  parameter int MAC_LEN = 17
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lcd_pkg::cmd_t                   cmd_i,
  input  logic [7:0]                      cmd_mac_i [MAC_LEN],
  output logic                            cmd_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            item_kind_o,
  output logic [1:0]                      command_code_o,
  output logic [1:0]                      new_mode_o,
  output logic                            event_kind_o,
  output logic [7:0]                      mac_char_o,
  output logic [lcd_pkg::MAC_POS_W-1:0]   mac_position_o,
  output logic                            last_o
);

  localparam int MW   = (MAC_LEN > 1) ? $clog2(MAC_LEN) : 1;
  localparam int PosW = lcd_pkg::MAC_POS_W;

  logic          out_valid_q;
  logic          pending_q;
  logic [MW-1:0] cnt_q;
  logic [7:0]    mac_store_q [MAC_LEN];

  logic          kind_q;
  logic [1:0]    code_q;
  logic [1:0]    mode_q;
  logic          event_q;
  logic [7:0]    char_q;
  logic [PosW-1:0] pos_q;
  logic          last_q;

  logic          slot_free;
  logic          take_cmd;
  logic          take_mac;
  logic          mac_final;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign cmd_ready_o = slot_free && !pending_q;
  assign take_cmd    = cmd_i.valid && cmd_ready_o;
  assign take_mac    = pending_q && slot_free;
  assign mac_final   = (cnt_q == MW'(MAC_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pending_q   <= 1'b0;
      cnt_q       <= '0;
      for (int i = 0; i < MAC_LEN; i++) begin
        mac_store_q[i] <= 8'd0;
      end
    end else begin
      if (take_cmd) begin
        out_valid_q <= 1'b1;
        pending_q   <= cmd_i.has_mac;
        cnt_q       <= '0;
        // scan clears the mac, rssi loads it from the line
        if (cmd_i.has_mac) begin
          for (int i = 0; i < MAC_LEN; i++) begin
            mac_store_q[i] <= cmd_i.load_mac ? cmd_mac_i[i] : 8'd0;
          end
        end
      end else if (take_mac) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + MW'(1);
        if (mac_final) begin
          pending_q <= 1'b0;
        end
      end else if (slot_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_cmd) begin
      kind_q  <= lcd_pkg::KIND_CMD;
      code_q  <= cmd_i.code;
      mode_q  <= lcd_pkg::mode_of(cmd_i.code);
      event_q <= (cmd_i.code == lcd_pkg::CMD_STOP) ? lcd_pkg::EV_STOP
                                                   : lcd_pkg::EV_RX_NOTIFY;
      char_q  <= 8'd0;
      pos_q   <= '0;
      last_q  <= !cmd_i.has_mac;
    end else if (take_mac) begin
      kind_q  <= lcd_pkg::KIND_MAC;
      code_q  <= lcd_pkg::CMD_NFC;
      mode_q  <= lcd_pkg::MODE_IDLE;
      event_q <= lcd_pkg::EV_RX_NOTIFY;
      char_q  <= mac_store_q[cnt_q];
      pos_q   <= PosW'(cnt_q);
      last_q  <= mac_final;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign item_kind_o    = kind_q;
  assign command_code_o = code_q;
  assign new_mode_o     = mode_q;
  assign event_kind_o   = event_q;
  assign mac_char_o     = char_q;
  assign mac_position_o = pos_q;
  assign last_o         = last_q;

endmodule

/* src/line_command_decoder.sv */
`timescale 1ns / 1ps

// Line command decoder: takes one received byte per request and builds a line of up to
// LINE_MAX characters, dropping bytes past that. CR or LF ends a non-empty line; the line
// is matched up to its first zero byte exactly against the nfc read, ble scan and ble stop
// command words, and by prefix against the ble rssi word with its colon (followed by up to
// MAC_LEN mac characters). Matching runs as each byte arrives, so ordinary bytes are taken
// one per cycle at all times. A matched line gives one command result, and the scan and
// rssi commands add MAC_LEN mac character results, one per cycle from the output register
// while the output is not stalled; a line end that arrives while those are still going out
// is held off until the sequencer has issued the last mac character.

module line_command_decoder #(
  parameter int LINE_MAX = 62,
  parameter int MAC_LEN  = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          item_kind_o,
  output logic [1:0]                    command_code_o,
  output logic [1:0]                    new_mode_o,
  output logic                          event_kind_o,
  output logic [7:0]                    mac_char_o,
  output logic [lcd_pkg::MAC_POS_W-1:0] mac_position_o,
  output logic                          last_o
);

  lcd_pkg::cmd_t cmd;
  logic [7:0]    cmd_mac [MAC_LEN];
  logic          cmd_ready;

  lcd_line_tracker #(
    .LINE_MAX(LINE_MAX),
    .MAC_LEN (MAC_LEN)
  ) u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd),
    .cmd_mac_o  (cmd_mac)
  );

  lcd_result_seq #(
    .MAC_LEN(MAC_LEN)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cmd_mac_i     (cmd_mac),
    .cmd_ready_o   (cmd_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_kind_o   (item_kind_o),
    .command_code_o(command_code_o),
    .new_mode_o    (new_mode_o),
    .event_kind_o  (event_kind_o),
    .mac_char_o    (mac_char_o),
    .mac_position_o(mac_position_o),
    .last_o        (last_o)
  );

endmodule

/* bench/line_command_decoder_tb.sv */
`timescale 1ns / 1ps

module line_command_decoder_tb;

  localparam int LINE_MAX     = 62;
  localparam int MAC_LEN      = 17;
  localparam int TOTAL_BYTES  = 260;
  localparam int QUIET_TAIL   = 40;
  localparam int DRAIN_CYCLES = 60;
  localparam int STUCK_LIMIT  = 5000;

  localparam int K_NFC  = 0;
  localparam int K_SCAN = 1;
  localparam int K_RSSI = 2;
  localparam int K_STOP = 3;

  typedef struct packed {
    lcd_pkg::kind_e                kind;
    lcd_pkg::cmd_e                 code;
    lcd_pkg::mode_e                mode;
    lcd_pkg::event_e               ev;
    logic [7:0]                    ch;
    logic [lcd_pkg::MAC_POS_W-1:0] pos;
    logic                          last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] rx_byte_i = 8'd0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic item_kind_o;
  logic [1:0] command_code_o;
  logic [1:0] new_mode_o;
  logic event_kind_o;
  logic [7:0] mac_char_o;
  logic [lcd_pkg::MAC_POS_W-1:0] mac_position_o;
  logic last_o;

  line_command_decoder #(
    .LINE_MAX(LINE_MAX),
    .MAC_LEN (MAC_LEN)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_kind_o   (item_kind_o),
    .command_code_o(command_code_o),
    .new_mode_o    (new_mode_o),
    .event_kind_o  (event_kind_o),
    .mac_char_o    (mac_char_o),
    .mac_position_o(mac_position_o),
    .last_o        (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  logic [7:0] rx_stream[$];
  result_t    pending_results[$];
  int         mismatches = 0;
  int         mac_lines = 0;

  logic [71:0] cmd_words[4];
  int          cmd_lens[4];

  // decoder state as the bench sees it
  logic [7:0]     line_chars[LINE_MAX];
  int             line_fill = 0;
  lcd_pkg::mode_e cur_mode = lcd_pkg::MODE_IDLE;
  logic [7:0]     mac_chars[MAC_LEN];

  function automatic logic [7:0] word_char(int k, int i);
    return cmd_words[k][8 * (cmd_lens[k] - 1 - i) +: 8];
  endfunction

  function automatic bit line_has(int k);
    for (int i = 0; i < cmd_lens[k]; i++) begin
      if (line_chars[i] != word_char(k, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_command(lcd_pkg::cmd_e code, lcd_pkg::event_e ev, logic last);
    result_t r;
    r = '0;
    r.kind = lcd_pkg::KIND_CMD;
    r.code = code;
    r.mode = cur_mode;
    r.ev   = ev;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void push_mac();
    result_t r;
    for (int i = 0; i < MAC_LEN; i++) begin
      r = '0;
      r.kind = lcd_pkg::KIND_MAC;
      r.ch   = mac_chars[i];
      r.pos  = lcd_pkg::MAC_POS_W'(i);
      r.last = (i == MAC_LEN - 1);
      pending_results.push_back(r);
    end
  endfunction

  function automatic void decode_rx_byte(logic [7:0] b);
    int eff;
    if (b != lcd_pkg::CHAR_LF && b != lcd_pkg::CHAR_CR) begin
      if (line_fill < LINE_MAX) begin
        line_chars[line_fill] = b;
        line_fill++;
      end
      return;
    end
    if (line_fill == 0) return;
    eff = 0;
    while (eff < line_fill && line_chars[eff] != 8'd0) eff++;
    if (eff == lcd_pkg::WORD_LEN && line_has(K_NFC)) begin
      cur_mode = lcd_pkg::MODE_NFC;
      push_command(lcd_pkg::CMD_NFC, lcd_pkg::EV_RX_NOTIFY, 1'b1);
    end else if (eff == lcd_pkg::WORD_LEN && line_has(K_SCAN)) begin
      cur_mode = lcd_pkg::MODE_BLE_REG;
      foreach (mac_chars[i]) mac_chars[i] = 8'd0;
      push_command(lcd_pkg::CMD_SCAN, lcd_pkg::EV_RX_NOTIFY, 1'b0);
      push_mac();
    end else if (eff >= lcd_pkg::PREFIX_LEN && line_has(K_RSSI)) begin
      cur_mode = lcd_pkg::MODE_BLE_TRK;
      for (int i = 0; i < MAC_LEN; i++) begin
        mac_chars[i] = (lcd_pkg::PREFIX_LEN + i < eff) ?
                       line_chars[lcd_pkg::PREFIX_LEN + i] : 8'd0;
      end
      push_command(lcd_pkg::CMD_RSSI, lcd_pkg::EV_RX_NOTIFY, 1'b0);
      push_mac();
    end else if (eff == lcd_pkg::WORD_LEN && line_has(K_STOP)) begin
      cur_mode = lcd_pkg::MODE_IDLE;
      push_command(lcd_pkg::CMD_STOP, lcd_pkg::EV_STOP, 1'b1);
    end
    line_fill = 0;
  endfunction

  // ---- stimulus helpers ----

  function automatic logic [7:0] text_byte(bit allow_zero);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(allow_zero ? 0 : 1, 255));
    end while (c == lcd_pkg::CHAR_LF || c == lcd_pkg::CHAR_CR);
    return c;
  endfunction

  function automatic logic [7:0] line_end();
    return ($urandom_range(0, 1) == 1) ? lcd_pkg::CHAR_CR : lcd_pkg::CHAR_LF;
  endfunction

  // bad_pos < 0 keeps the word intact, otherwise one bit of that char flips
  function automatic void queue_word(int k, int bad_pos);
    logic [7:0] c;
    for (int i = 0; i < cmd_lens[k]; i++) begin
      c = word_char(k, i);
      if (i == bad_pos) c = c ^ (8'd1 << $urandom_range(0, 7));
      rx_stream.push_back(c);
    end
  endfunction

  function automatic void queue_text(int count, bit allow_zero);
    for (int i = 0; i < count; i++) rx_stream.push_back(text_byte(allow_zero));
  endfunction

  function automatic void queue_random_line();
    int k;
    k = $urandom_range(0, 3);
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        queue_word(K_NFC, -1);
        rx_stream.push_back(line_end());
      end
      3, 4, 5: begin
        queue_word(K_SCAN, -1);
        rx_stream.push_back(line_end());
        mac_lines++;
      end
      6, 7, 8, 9: begin
        queue_word(K_RSSI, -1);
        queue_text($urandom_range(0, 20), 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          rx_stream.push_back(8'd0);
          queue_text($urandom_range(0, 5), 1'b1);
        end
        rx_stream.push_back(line_end());
        mac_lines++;
      end
      10, 11: begin
        queue_word(K_STOP, -1);
        rx_stream.push_back(line_end());
      end
      12, 13: begin
        // near misses: one bad char, one char short or one char long (an rssi word is left whole)
        case ($urandom_range(0, 2))
          0: queue_word(k, $urandom_range(0, cmd_lens[k] - 1));
          1: begin
            queue_word(k, -1);
            void'(rx_stream.pop_back());
          end
          default: begin
            queue_word(k, -1);
            if (k != K_RSSI) rx_stream.push_back(text_byte(1'b0));
          end
        endcase
        rx_stream.push_back(line_end());
      end
      14: begin
        // a zero cuts off whatever follows the command
        queue_word(k, -1);
        rx_stream.push_back(8'd0);
        queue_text($urandom_range(0, 10), 1'b1);
        rx_stream.push_back(line_end());
        if (k == K_SCAN || k == K_RSSI) mac_lines++;
      end
      15: rx_stream.push_back(line_end());
      16, 17: begin
        for (int i = 0; i < $urandom_range(1, 8); i++) begin
          rx_stream.push_back(8'($urandom_range(0, 255)));
        end
      end
      18: begin
        // overflow of the line store
        queue_word(k, -1);
        queue_text($urandom_range(LINE_MAX - 8, LINE_MAX + 12), 1'b0);
        rx_stream.push_back(line_end());
        if (k == K_RSSI) mac_lines++;
      end
      default: begin
        rx_stream.push_back(text_byte(1'b1));
        queue_word(k, -1);
        rx_stream.push_back(line_end());
      end
    endcase
  endfunction

  // ---- request driver ----

  int send_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_rx_byte(rx_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (rx_stream.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 6) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_stream.pop_front();
        end
      end
    end
  end

  // ---- result monitor ----

  int hold_gap = 0;

  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.kind = lcd_pkg::kind_e'(item_kind_o);
        seen.code = lcd_pkg::cmd_e'(command_code_o);
        seen.mode = lcd_pkg::mode_e'(new_mode_o);
        seen.ev   = lcd_pkg::event_e'(event_kind_o);
        seen.ch   = mac_char_o;
        seen.pos  = mac_position_o;
        seen.last = last_o;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: kind %0d cmd %0d mode %0d ev %0d",
                     seen.kind, seen.code, seen.mode, seen.ev,
                     " char %02h pos %0d last %0d", seen.ch, seen.pos, seen.last);
          end
        end else begin
          want = pending_results.pop_front();
          if (seen.kind !== want.kind || seen.code !== want.code || seen.mode !== want.mode ||
              seen.ev !== want.ev || seen.ch !== want.ch || seen.pos !== want.pos ||
              seen.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: expected kind %0d cmd %0d mode %0d ev %0d",
                       $realtime, want.kind, want.code, want.mode, want.ev,
                       " char %02h pos %0d last %0d", want.ch, want.pos, want.last);
              $display("                 got kind %0d cmd %0d mode %0d ev %0d",
                       seen.kind, seen.code, seen.mode, seen.ev,
                       " char %02h pos %0d last %0d", seen.ch, seen.pos, seen.last);
            end
          end
        end
      end
      if (hold_gap > 0) begin
        hold_gap--;
        out_stall_i <= 1'b1;
      end else if (rx_stream.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        hold_gap = $urandom_range(1, 6) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---- watchdog: cycles with no request and no result taken ----

  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    cmd_words[K_NFC]  = {8'd0, lcd_pkg::WORD_NFC};
    cmd_words[K_SCAN] = {8'd0, lcd_pkg::WORD_SCAN};
    cmd_words[K_RSSI] = lcd_pkg::WORD_RSSI;
    cmd_words[K_STOP] = {8'd0, lcd_pkg::WORD_STOP};
    cmd_lens[K_NFC]   = lcd_pkg::WORD_LEN;
    cmd_lens[K_SCAN]  = lcd_pkg::WORD_LEN;
    cmd_lens[K_RSSI]  = lcd_pkg::PREFIX_LEN;
    cmd_lens[K_STOP]  = lcd_pkg::WORD_LEN;
    foreach (line_chars[i]) line_chars[i] = 8'd0;
    foreach (mac_chars[i]) mac_chars[i] = 8'd0;

    // directed lines: empty line, each command, full and short mac, zero inside,
    // overflow, near misses
    rx_stream.push_back(lcd_pkg::CHAR_LF);
    queue_word(K_NFC, -1);
    rx_stream.push_back(lcd_pkg::CHAR_CR);
    queue_word(K_RSSI, -1);
    rx_stream.push_back(8'hFF);
    rx_stream.push_back(8'h80);
    rx_stream.push_back(8'h7F);
    rx_stream.push_back(8'h01);
    queue_text(MAC_LEN - 4 + 3, 1'b0);
    rx_stream.push_back(lcd_pkg::CHAR_LF);
    queue_word(K_SCAN, -1);
    rx_stream.push_back(lcd_pkg::CHAR_LF);
    queue_word(K_RSSI, -1);
    queue_text(2, 1'b0);
    rx_stream.push_back(lcd_pkg::CHAR_CR);
    queue_word(K_STOP, -1);
    rx_stream.push_back(lcd_pkg::CHAR_LF);
    queue_word(K_NFC, -1);
    rx_stream.push_back(8'd0);
    queue_text(2, 1'b1);
    rx_stream.push_back(lcd_pkg::CHAR_CR);
    queue_word(K_RSSI, -1);
    queue_text(2, 1'b0);
    rx_stream.push_back(8'd0);
    queue_text(2, 1'b0);
    rx_stream.push_back(lcd_pkg::CHAR_CR);
    queue_word(K_RSSI, -1);
    queue_text(LINE_MAX, 1'b0);
    rx_stream.push_back(lcd_pkg::CHAR_LF);
    queue_word(K_NFC, 3);
    rx_stream.push_back(lcd_pkg::CHAR_LF);
    rx_stream.push_back(8'd0);
    queue_word(K_STOP, -1);
    rx_stream.push_back(lcd_pkg::CHAR_CR);
    queue_word(K_RSSI, -1);
    void'(rx_stream.pop_back());
    rx_stream.push_back(lcd_pkg::CHAR_LF);

    while (rx_stream.size() < TOTAL_BYTES - 20 || mac_lines < 2) queue_random_line();
    // make sure the tail line is closed
    rx_stream.push_back(lcd_pkg::CHAR_LF);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (rx_stream.size() != 0 || in_valid_i || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
